[rtl/isort_pkg.sv]
package isort_pkg;

    // Default number of records held in the store
    localparam int DEPTH_DEFAULT = 32;

    localparam int KEY_W = 32;
    localparam int PAY_W = 16;

    // Input word: one record
    typedef struct packed {
        logic signed [KEY_W-1:0] sort_key;
        logic [PAY_W-1:0]        payload;
        logic                    final_record;
    } isort_in_t;

    // Output word: one record of the sorted run
    typedef struct packed {
        logic signed [KEY_W-1:0] out_key;
        logic [PAY_W-1:0]        out_payload;
        logic                    run_end;
        logic                    records_dropped;
    } isort_out_t;

    // One stored slot
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
    } isort_slot_t;

    // Controller to datapath
    typedef struct packed {
        logic insert;
        logic drain;
    } isort_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last_slot;
    } isort_status_t;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } isort_state_t;

endpackage

[rtl/isort_ctrl.sv]
module isort_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    final_record,
    input  isort_pkg::isort_status_t status,
    output isort_pkg::isort_cmd_t    cmd,
    output logic                    busy,
    output logic                    strobe
);

    isort_pkg::isort_state_t state_reg;
    isort_pkg::isort_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= isort_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        strobe     = 1'b0;
        unique case (state_reg)
            isort_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.insert = 1'b1;
                    if (final_record)
                    begin
                        state_next = isort_pkg::ST_DRAIN;
                    end
                end
            end
            isort_pkg::ST_DRAIN:
            begin
                strobe    = 1'b1;
                cmd.drain = 1'b1;
                if (status.last_slot)
                begin
                    state_next = isort_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = isort_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/isort_datapath.sv]
module isort_datapath
#(
    parameter int DEPTH = isort_pkg::DEPTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  isort_pkg::isort_cmd_t    cmd,
    input  isort_pkg::isort_in_t     item,
    output isort_pkg::isort_status_t status,
    output isort_pkg::isort_out_t    result
);

    localparam int FW = $clog2(DEPTH + 1);

    isort_pkg::isort_slot_t slot_reg  [DEPTH];
    isort_pkg::isort_slot_t slot_next [DEPTH];
    logic [FW-1:0]          fill_reg;
    logic [FW-1:0]          fill_next;
    logic                   overflow_reg;
    logic                   overflow_next;
    logic [DEPTH-1:0]       gt;
    logic                   full;
    isort_pkg::isort_slot_t new_slot;

    assign full          = (fill_reg == FW'(DEPTH));
    assign new_slot.key  = item.sort_key;
    assign new_slot.payload = item.payload;

    // Flag every held slot whose key is above the incoming key
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            gt[i] = (FW'(i) < fill_reg) && (slot_reg[i].key > item.sort_key);
        end
    end

    // Per-slot compare and shift for insert, shift down for drain
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_next[i] = slot_reg[i];
            if (cmd.insert && !full)
            begin
                if (i > 0 && gt[(i > 0) ? i - 1 : 0])
                begin
                    slot_next[i] = slot_reg[(i > 0) ? i - 1 : 0];
                end
                else if (gt[i] || (FW'(i) == fill_reg))
                begin
                    slot_next[i] = new_slot;
                end
            end
            else if (cmd.drain && (i < DEPTH - 1))
            begin
                slot_next[i] = slot_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    // Fill count and drop flag
    always_comb
    begin
        fill_next     = fill_reg;
        overflow_next = overflow_reg;
        if (cmd.insert)
        begin
            if (full)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                fill_next = fill_reg + FW'(1);
            end
        end
        else if (cmd.drain)
        begin
            fill_next = fill_reg - FW'(1);
            if (fill_reg == FW'(1))
            begin
                overflow_next = 1'b0;
            end
        end
    end

    // Hold slots; no reset on payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            fill_reg     <= fill_next;
            overflow_reg <= overflow_next;
        end
    end

    // Present the head slot
    assign status.last_slot       = (fill_reg == FW'(1));
    assign result.out_key         = slot_reg[0].key;
    assign result.out_payload     = slot_reg[0].payload;
    assign result.run_end         = (fill_reg == FW'(1));
    assign result.records_dropped = overflow_reg;

endmodule

[rtl/insertion_sorter.sv]
// Channel  Handshake      Word                   Direction
// input    start / busy   item   (isort_in_t)    in, taken when start && !busy
// output   strobe         result (isort_out_t)   out, one word per strobe
//
// One record is taken per cycle while busy is low; each DEPTH slot compares its key with the
// incoming key and shifts up in the same cycle. On the final record the run drains from
// slot 0, one word per cycle, until the word flagged run_end; busy stays high during the
// drain. The receiver cannot stall. Reset empties the store at once (fill count cleared,
// no sweep).
module insertion_sorter
#(
    parameter int DEPTH = isort_pkg::DEPTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  isort_pkg::isort_in_t  item,
    output logic                  strobe,
    output isort_pkg::isort_out_t result
);

    isort_pkg::isort_cmd_t    cmd;
    isort_pkg::isort_status_t status;

    isort_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .final_record (item.final_record),
        .status       (status),
        .cmd          (cmd),
        .busy         (busy),
        .strobe       (strobe)
    );

    isort_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .status (status),
        .result (result)
    );

`ifndef SYNTHESIS
    // A result word only appears while busy
    assert property (@(posedge clk) disable iff (!rst_n) strobe |-> busy)
        else $error("result word outside busy");

    // Final record starts the drain in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.final_record) |=> strobe)
        else $error("drain did not follow final record");

    // Run continues until run_end, then stops
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.run_end) |=> strobe)
        else $error("run broke off before run_end");

    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.run_end) |=> !strobe)
        else $error("word emitted after run_end");
`endif

endmodule

[test/isort_checker.sv]
module isort_checker
#(
    parameter int DEPTH = isort_pkg::DEPTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  isort_pkg::isort_in_t  item,
    input  logic                  strobe,
    input  isort_pkg::isort_out_t result,
    input  logic                  end_check,
    output int                    pending,
    output int                    fail_count,
    output int                    words_checked
);

    timeunit 1ns;
    timeprecision 1ps;

    // Own copy of the sorted store
    isort_pkg::isort_slot_t sorted_slots [DEPTH];
    int                     slot_fill;
    logic                   drop_seen;
    bit                     leftovers_done;

    // Words of the sorted run still owed by the block, oldest first
    isort_pkg::isort_out_t  owed_words [$];

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        fail_count++;
    endtask

    // Insert one record in stable ascending order; queue the run on the final record
    task automatic insert_record(input isort_pkg::isort_in_t rec);
        int pos;
        isort_pkg::isort_out_t word;
        if (slot_fill < DEPTH)
        begin
            pos = slot_fill;
            while (pos > 0 && $signed(sorted_slots[pos-1].key) > $signed(rec.sort_key))
            begin
                sorted_slots[pos] = sorted_slots[pos-1];
                pos--;
            end
            sorted_slots[pos].key     = rec.sort_key;
            sorted_slots[pos].payload = rec.payload;
            slot_fill++;
        end
        else
        begin
            drop_seen = 1'b1;
        end
        if (rec.final_record)
        begin
            for (int i = 0; i < slot_fill; i++)
            begin
                word.out_key         = sorted_slots[i].key;
                word.out_payload     = sorted_slots[i].payload;
                word.run_end         = (i == slot_fill - 1);
                word.records_dropped = drop_seen;
                owed_words.push_back(word);
            end
            slot_fill = 0;
            drop_seen = 1'b0;
        end
    endtask

    // Compare one emitted word with the oldest owed word
    task automatic check_word(input isort_pkg::isort_out_t got);
        isort_pkg::isort_out_t want;
        if (owed_words.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word key %0d payload %h",
                                      got.out_key, got.out_payload));
            return;
        end
        want = owed_words.pop_front();
        words_checked++;
        if (got.out_key !== want.out_key)
            report_mismatch($sformatf("out_key %0d, want %0d", got.out_key, want.out_key));
        if (got.out_payload !== want.out_payload)
            report_mismatch($sformatf("out_payload %h, want %h (key %0d)",
                                      got.out_payload, want.out_payload, want.out_key));
        if (got.run_end !== want.run_end)
            report_mismatch($sformatf("run_end %b, want %b (key %0d)",
                                      got.run_end, want.run_end, want.out_key));
        if (got.records_dropped !== want.records_dropped)
            report_mismatch($sformatf("records_dropped %b, want %b (key %0d)",
                                      got.records_dropped, want.records_dropped,
                                      want.out_key));
    endtask

    // Watch both channels at every edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_fill      = 0;
            drop_seen      = 1'b0;
            leftovers_done = 1'b0;
            owed_words.delete();
            fail_count     = 0;
            words_checked  = 0;
            pending       <= 0;
        end
        else
        begin
            if (strobe)
                check_word(result);
            if (start && !busy)
                insert_record(item);
            if (end_check && !leftovers_done)
            begin
                leftovers_done = 1'b1;
                if (owed_words.size() != 0)
                    report_mismatch($sformatf("%0d words never emitted", owed_words.size()));
            end
            pending <= owed_words.size();
        end
    end

endmodule

[test/tb.sv]
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = isort_pkg::DEPTH_DEFAULT;
    localparam int RECORD_GOAL = 200;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    isort_pkg::isort_in_t  item      = '0;
    logic                  end_check = 1'b0;
    logic                  busy;
    logic                  strobe;
    isort_pkg::isort_out_t result;
    int                    pending;
    int                    fail_count;
    int                    words_checked;

    int         records_sent;
    int         sets_sent;
    int         overfull_sets;
    bit         steady_set;
    int         set_size;

    always #5 clk = ~clk;

    insertion_sorter #(
        .DEPTH (DEPTH)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .strobe (strobe),
        .result (result)
    );

    isort_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .strobe        (strobe),
        .result        (result),
        .end_check     (end_check),
        .pending       (pending),
        .fail_count    (fail_count),
        .words_checked (words_checked)
    );

    // Mix full-range keys, a narrow band that forces ties, and the extremes
    function automatic logic signed [isort_pkg::KEY_W-1:0] draw_key();
        logic signed [isort_pkg::KEY_W-1:0] k;
        case ($urandom_range(0, 9))
            5, 6, 7: k = int'($urandom_range(0, 6)) - 3;
            8:       k = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            9:       k = $urandom_range(0, 1) ? 32'sh0000_0000 : 32'shffff_ffff;
            default: k = $urandom;
        endcase
        return k;
    endfunction

    // Offer one word and hold it until taken, then idle for a drawn gap
    task automatic put_record(input logic signed [isort_pkg::KEY_W-1:0] key,
                              input logic [isort_pkg::PAY_W-1:0] pay,
                              input logic last);
        int gap;
        gap = steady_set ? 0 : $urandom_range(0, 4);
        item  <= '{sort_key: key, payload: pay, final_record: last};
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        records_sent++;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random_set(input int size);
        steady_set = ($urandom_range(0, 2) == 0);
        for (int i = 0; i < size; i++)
            put_record(draw_key(), 16'($urandom_range(0, 16'hffff)), i == size - 1);
        steady_set = 1'b0;
        sets_sent++;
        if (size > DEPTH)
            overfull_sets++;
    endtask

    // Drop start and hold off until every owed word has come out
    task automatic wait_for_drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes, ties in arrival order, both payload extremes
        put_record(32'sh7fff_ffff, 16'h0000, 1'b0);
        put_record(32'sh8000_0000, 16'hffff, 1'b0);
        put_record(32'sd0,         16'h0001, 1'b0);
        put_record(-32'sd1,        16'h0002, 1'b0);
        put_record(32'sd5,         16'h0003, 1'b0);
        put_record(32'sd5,         16'h0004, 1'b0);
        put_record(32'sh8000_0000, 16'h0005, 1'b0);
        put_record(32'sd5,         16'h0006, 1'b0);
        put_record(32'sh7fff_ffff, 16'h0007, 1'b1);
        sets_sent++;

        // Run of one record
        put_record(-32'sd1, 16'hffff, 1'b1);
        sets_sent++;

        // Strictly descending arrival, every record shifts the whole run
        put_record(32'sd300,  16'h1111, 1'b0);
        put_record(32'sd200,  16'h2222, 1'b0);
        put_record(32'sd100,  16'h4444, 1'b0);
        put_record(32'sd0,    16'h8888, 1'b0);
        put_record(-32'sd100, 16'haaaa, 1'b0);
        put_record(-32'sd200, 16'h5555, 1'b1);
        sets_sent++;

        // Store exactly full, then full with the final record dropped
        send_random_set(DEPTH);
        send_random_set(DEPTH + 1);
        wait_for_drain();

        // Random sets, mostly short, now and then near or past the store depth
        while (records_sent < RECORD_GOAL)
        begin
            if ($urandom_range(0, 9) == 0)
                set_size = $urandom_range(DEPTH - 4, DEPTH + 8);
            else
                set_size = $urandom_range(1, 10);
            send_random_set(set_size);
            if ($urandom_range(0, 5) == 0)
                wait_for_drain();
        end

        wait_for_drain();
        repeat (DEPTH + 8) @(posedge clk);
        end_check <= 1'b1;
        repeat (2) @(posedge clk);

        $display("Sorted %0d records in %0d sets (%0d past store depth), %0d words checked.",
                 records_sent, sets_sent, overfull_sets, words_checked);
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d words still owed.", pending);
        $display("tb failed");
        $finish;
    end

endmodule
